// ----- rtl/assert_macros.svh -----
// assertion helper macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// condition must never be seen at a rising edge outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// ----- rtl/bdwt_pkg.sv -----
// package: word types, register indexes and reset values for the debounce block
package bdwt_pkg;

   localparam int NOW_WIDTH          = 32;
   localparam int DEBOUNCE_WIDTH     = 16;
   localparam int IDLE_TIMEOUT_WIDTH = 24;
   localparam int CSR_DATA_WIDTH     = 24;

   localparam logic [DEBOUNCE_WIDTH-1:0]     DEBOUNCE_RESET     = 16'd60;
   localparam logic [IDLE_TIMEOUT_WIDTH-1:0] IDLE_TIMEOUT_RESET = 24'd30000;

   // register indexes of the csr port
   typedef enum logic [0:0] {
      CSR_DEBOUNCE_MS     = 1'b0,
      CSR_IDLE_TIMEOUT_MS = 1'b1
   } csr_index_type;

   // one poll
   typedef struct packed {
      logic [NOW_WIDTH-1:0] now_ms;
      logic                 left_level;
      logic                 right_level;
   } req_word_type;

   // one result
   typedef struct packed {
      logic left_event;
      logic left_pressed;
      logic right_event;
      logic right_pressed;
      logic wake_pulse;
      logic sleep_pulse;
      logic is_active;
   } rsp_word_type;

endpackage

// ----- rtl/bdwt_if.sv -----
// interfaces: poll channel and result channel with valid/ready handshake
interface bdwt_req_if;
   import bdwt_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface bdwt_rsp_if;
   import bdwt_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

// ----- rtl/bdwt_button.sv -----
// one button: stable level, debounce deadline and change acceptance
module bdwt_button #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  level,
   input  logic [TIME_WIDTH-1:0] now,
   input  logic [TIME_WIDTH-1:0] debounce,
   output logic                  accept
);

   logic                  stable_ff;
   logic                  stable_in;
   logic                  set_ff;
   logic                  set_in;
   logic [TIME_WIDTH-1:0] deadline_ff;
   logic [TIME_WIDTH-1:0] deadline_in;
   logic                  differ;
   logic                  passed;
   logic [TIME_WIDTH-1:0] since;

   // wrap-safe compare: deadline lies strictly before now
   always_comb begin
      differ = level != stable_ff;
      since  = now - deadline_ff;
      passed = (|since) && !since[TIME_WIDTH-1];
      accept = differ && (!set_ff || passed);
   end

   // any differing level restarts the quiet time
   always_comb begin
      stable_in   = accept ? level : stable_ff;
      deadline_in = differ ? now + debounce : deadline_ff;
      set_in      = set_ff | differ;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff   <= 1'b1;
         set_ff      <= 1'b0;
         deadline_ff <= '0;
      end else if (step) begin
         stable_ff   <= stable_in;
         set_ff      <= set_in;
         deadline_ff <= deadline_in;
      end
   end

endmodule

// ----- rtl/button_debounce_with_wake_timeout.sv -----
// top level: two-button debounce with wake on change and sleep after inactivity
//
// req carries one poll word (millisecond timestamp, raw active-low levels of the
// left and right buttons); rsp returns exactly one result word per poll, in order.
// csr_wr_en writes csr_wdata to register csr_index (0 debounce_ms, 1
// idle_timeout_ms) at the clock edge; write only while no poll is in flight.
// A poll is registered in the input register on acceptance and evaluated from
// there; its result is loaded into the output register once that register is
// free, which raises rsp.valid.
// Throughput is one poll per cycle while rsp.ready stays high; the button and activity
// state is updated in the same cycle the result is loaded, so the next poll sees it at once.
// The output register and the input register form a two-entry buffer: while
// rsp.ready is low one more poll is taken, then req.ready drops until the
// result is taken. Results are held stable while stalled.
// Reset (synchronous, active high) empties both registers, sets both buttons
// released with expired deadlines, the block idle, and the registers to 60 ms
// and 30000 ms.
`include "assert_macros.svh"

module button_debounce_with_wake_timeout #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   bdwt_req_if.sink                               req,
   bdwt_rsp_if.source                             rsp,
   input  logic                                   csr_wr_en,
   input  bdwt_pkg::csr_index_type                csr_index,
   input  logic [bdwt_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   import bdwt_pkg::*;

   logic [DEBOUNCE_WIDTH-1:0]     debounce_ff;
   logic [IDLE_TIMEOUT_WIDTH-1:0] idle_timeout_ff;

   logic                  s1_valid_ff;
   req_word_type          s1_word_ff;
   logic                  out_valid_ff;
   rsp_word_type          out_word_ff;
   rsp_word_type          out_word_in;

   logic                  active_ff;
   logic                  active_in;
   logic [TIME_WIDTH-1:0] idle_deadline_ff;
   logic [TIME_WIDTH-1:0] idle_deadline_in;

   logic                  out_free;
   logic                  s1_adv;
   logic                  req_take;

   logic [TIME_WIDTH-1:0] now_t;
   logic [TIME_WIDTH-1:0] debounce_t;
   logic [TIME_WIDTH-1:0] idle_t;
   logic [TIME_WIDTH-1:0] idle_since;
   logic                  left_accept;
   logic                  right_accept;
   logic                  active_mid;
   logic                  active_pre;
   logic                  idle_passed;
   logic                  go_sleep;

   // handshake and buffer control
   always_comb begin
      out_free  = !out_valid_ff || rsp.ready;
      s1_adv    = s1_valid_ff && out_free;
      req.ready = !s1_valid_ff || out_free;
      req_take  = req.valid && req.ready;
      rsp.valid = out_valid_ff;
      rsp.word  = out_word_ff;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff     <= DEBOUNCE_RESET;
         idle_timeout_ff <= IDLE_TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE_MS: begin
               debounce_ff <= csr_wdata[DEBOUNCE_WIDTH-1:0];
            end
            CSR_IDLE_TIMEOUT_MS: begin
               idle_timeout_ff <= csr_wdata[IDLE_TIMEOUT_WIDTH-1:0];
            end
         endcase
      end
   end

   // times at internal width
   always_comb begin
      now_t      = TIME_WIDTH'(s1_word_ff.now_ms);
      debounce_t = TIME_WIDTH'(debounce_ff);
      idle_t     = TIME_WIDTH'(idle_timeout_ff);
   end

   bdwt_button #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_left (
      .clock    (clock),
      .reset    (reset),
      .step     (s1_adv),
      .level    (s1_word_ff.left_level),
      .now      (now_t),
      .debounce (debounce_t),
      .accept   (left_accept)
   );

   bdwt_button #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_right (
      .clock    (clock),
      .reset    (reset),
      .step     (s1_adv),
      .level    (s1_word_ff.right_level),
      .now      (now_t),
      .debounce (debounce_t),
      .accept   (right_accept)
   );

   // activity: left first, then right, then the timeout check
   always_comb begin
      active_mid       = active_ff | left_accept;
      active_pre       = active_mid | right_accept;
      idle_deadline_in = (left_accept || right_accept) ? now_t + idle_t : idle_deadline_ff;
      idle_since       = now_t - idle_deadline_in;
      idle_passed      = (|idle_since) && !idle_since[TIME_WIDTH-1];
      go_sleep         = active_pre && idle_passed;
      active_in        = active_pre && !go_sleep;

      out_word_in.left_event    = left_accept && active_ff;
      out_word_in.left_pressed  = left_accept && active_ff && !s1_word_ff.left_level;
      out_word_in.right_event   = right_accept && active_mid;
      out_word_in.right_pressed = right_accept && active_mid && !s1_word_ff.right_level;
      out_word_in.wake_pulse    = (left_accept && !active_ff) || (right_accept && !active_mid);
      out_word_in.sleep_pulse   = go_sleep;
      out_word_in.is_active     = active_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         active_ff        <= 1'b0;
         idle_deadline_ff <= '0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff     <= 1'b1;
            active_ff        <= active_in;
            idle_deadline_ff <= idle_deadline_in;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff <= req.word;
      end
      if (s1_adv) begin
         out_word_ff <= out_word_in;
      end
   end

   // checks
   `ASSERT_CLK(a_active_tracks_result, clock, reset, s1_adv |=> (rsp.word.is_active == active_ff), "result activity differs from state")
   `ASSERT_CLK(a_wake_only_from_idle, clock, reset, (s1_adv && active_ff) |=> !rsp.word.wake_pulse, "wake while already active")
   `ASSERT_CLK(a_sleep_needs_active, clock, reset, (s1_adv && !active_ff) |=> (!rsp.word.sleep_pulse || rsp.word.wake_pulse), "sleep from idle without wake")
   `ASSERT_NEVER(a_left_event_idle, clock, reset, s1_adv && !active_ff && out_word_in.left_event, "left event reported while idle")

endmodule
